/* hw/rtl/ucts_pkg.sv */
`timescale 1ns / 1ps

package ucts_pkg;

	// Default number of raw byte groups held between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Mode register codes
	localparam logic [1:0] MODE_PASS  = 2'd0;
	localparam logic [1:0] MODE_UPPER = 2'd1;
	localparam logic [1:0] MODE_LOWER = 2'd2;
	localparam logic [1:0] MODE_CAP   = 2'd3;

	// Codepoint limits and special values
	localparam int          CP_W       = 21;
	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_LIMIT   = 21'h110000;
	localparam logic [20:0] CP_4B      = 21'h010000;
	localparam logic [20:0] CP_3B      = 21'h000800;
	localparam logic [20:0] CP_2B      = 21'h000080;
	localparam logic [20:0] CASE_OFS   = 21'd32;

	// Input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       out_last;
	} out_beat_t;

	// One group of raw bytes ready to decode, as the front hands it to the back
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      cnt;
		logic            last;
		logic [1:0]      mode;
	} grp_t;

	// Sequence length announced by a lead byte, zero for a bad lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (!b[7]) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage

/* hw/rtl/ucts_front.sv */
`timescale 1ns / 1ps

module ucts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  ucts_pkg::in_beat_t in_data,
	input  logic              q_full,
	output logic              push,
	output ucts_pkg::grp_t    push_grp
);
	import ucts_pkg::*;

	logic [1:0] mode_q;
	logic [7:0] pend_q [3];
	logic [1:0] pcnt_q;
	logic [2:0] seqlen_q;

	logic       accept;
	logic [2:0] need;
	logic [2:0] n;
	logic       fire;
	logic       is_pass;

	// Take a beat whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_pass  = (mode_q == MODE_PASS);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Classify: does this byte close a group
	always_comb begin
		need = (pcnt_q == 2'd0) ? lead_len(in_data.in_byte) : seqlen_q;
		n    = {1'b0, pcnt_q} + 3'd1;
		fire = (need <= 3'd1) || (n >= need) || in_data.in_last;
	end

	// Assemble the group: held bytes first, then this byte
	always_comb begin
		push_grp.cnt  = is_pass ? 3'd1 : n;
		push_grp.last = in_data.in_last;
		push_grp.mode = mode_q;
		for (int i = 0; i < 3; i++) begin
			if (!is_pass && (2'(i) < pcnt_q)) begin
				push_grp.data[i] = pend_q[i];
			end else if (is_pass ? (i == 0) : (2'(i) == pcnt_q)) begin
				push_grp.data[i] = in_data.in_byte;
			end else begin
				push_grp.data[i] = 8'h00;
			end
		end
		push_grp.data[3] = (!is_pass && pcnt_q == 2'd3) ? in_data.in_byte : 8'h00;
	end

	assign push = accept && (is_pass || fire);

	// Pending sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q   <= 2'd0;
			seqlen_q <= 3'd0;
		end else if (accept) begin
			if (is_pass) begin
				if (in_data.in_last) begin
					pcnt_q   <= 2'd0;
					seqlen_q <= 3'd0;
				end
			end else if (fire) begin
				pcnt_q   <= 2'd0;
				seqlen_q <= 3'd0;
			end else begin
				pcnt_q   <= n[1:0];
				seqlen_q <= need;
			end
		end
	end

	// Hold bytes of an unfinished sequence
	always_ff @(posedge clk) begin
		if (accept && !is_pass && !fire) begin
			pend_q[pcnt_q] <= in_data.in_byte;
		end
	end

endmodule

/* hw/rtl/ucts_queue.sv */
`timescale 1ns / 1ps

module ucts_queue #(
	parameter int DEPTH = ucts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ucts_pkg::grp_t push_grp,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output ucts_pkg::grp_t head
);
	import ucts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Store a group
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_grp;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/ucts_back.sv */
`timescale 1ns / 1ps

module ucts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  ucts_pkg::grp_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output ucts_pkg::out_beat_t out_data
);
	import ucts_pkg::*;

	logic [1:0] pos_q;
	logic [1:0] idx_q;
	logic       cap_q;
	logic       out_valid_q;
	out_beat_t  out_data_q;

	logic [31:0]     sh;
	logic [7:0]      b0, b1, b2, b3;
	logic [2:0]      rem;
	logic [2:0]      len;
	logic [2:0]      used;
	logic [CP_W-1:0] cp;
	logic [CP_W-1:0] t;
	logic [CP_W-1:0] e;
	logic [2:0]      elen;
	logic [7:0]      ob;
	logic            sp, is_lo, is_up;
	logic            is_pass;
	logic            cp_end;
	logic [2:0]      nxt_pos;
	logic            grp_done;
	logic            step;

	assign is_pass = (head.mode == MODE_PASS);
	assign step    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = step && grp_done;

	// Decode one codepoint at the current position
	always_comb begin
		sh   = head.data >> {pos_q, 3'b000};
		b0   = sh[7:0];
		b1   = sh[15:8];
		b2   = sh[23:16];
		b3   = sh[31:24];
		rem  = head.cnt - {1'b0, pos_q};
		len  = lead_len(b0);
		used = 3'd1;
		cp   = CP_REPLACE;
		if (len == 3'd1) begin
			cp = {13'd0, b0};
		end else if (len == 3'd2 && rem >= 3'd2) begin
			cp   = {10'd0, b0[4:0], b1[5:0]};
			used = 3'd2;
		end else if (len == 3'd3 && rem >= 3'd3) begin
			cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			used = 3'd3;
		end else if (len == 3'd4 && rem >= 3'd4) begin
			cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			used = 3'd4;
		end
	end

	// Apply the case rule of the group's mode
	always_comb begin
		sp = (cp == 21'h20) || (cp == 21'h09) || (cp == 21'h0A) ||
		     (cp == 21'h0D) || (cp == 21'h0C) || (cp == 21'h0B);
		is_lo = (cp >= 21'h61) && (cp <= 21'h7A);
		is_up = (cp >= 21'h41) && (cp <= 21'h5A);
		case (head.mode)
			MODE_UPPER: t = is_lo ? cp - CASE_OFS : cp;
			MODE_LOWER: t = is_up ? cp + CASE_OFS : cp;
			MODE_CAP:   t = (!sp && cap_q && is_lo) ? cp - CASE_OFS : cp;
			default:    t = cp;
		endcase
	end

	// Encode in shortest form, one byte per step
	always_comb begin
		e = (t >= CP_LIMIT) ? CP_REPLACE : t;
		if (e < CP_2B) begin
			elen = 3'd1;
		end else if (e < CP_3B) begin
			elen = 3'd2;
		end else if (e < CP_4B) begin
			elen = 3'd3;
		end else begin
			elen = 3'd4;
		end
		case (elen)
			3'd1: ob = e[7:0];
			3'd2: ob = (idx_q == 2'd0) ? {3'b110, e[10:6]} : {2'b10, e[5:0]};
			3'd3: begin
				case (idx_q)
					2'd0:    ob = {4'b1110, e[15:12]};
					2'd1:    ob = {2'b10, e[11:6]};
					default: ob = {2'b10, e[5:0]};
				endcase
			end
			default: begin
				case (idx_q)
					2'd0:    ob = {5'b11110, e[20:18]};
					2'd1:    ob = {2'b10, e[17:12]};
					2'd2:    ob = {2'b10, e[11:6]};
					default: ob = {2'b10, e[5:0]};
				endcase
			end
		endcase
		if (is_pass) begin
			ob = head.data[0];
		end
		cp_end   = (({1'b0, idx_q} + 3'd1) == elen);
		nxt_pos  = {1'b0, pos_q} + used;
		grp_done = is_pass || (cp_end && (nxt_pos == head.cnt));
	end

	// Walk positions and bytes inside the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			idx_q <= 2'd0;
			cap_q <= 1'b1;
		end else if (step) begin
			if (grp_done) begin
				pos_q <= 2'd0;
				idx_q <= 2'd0;
			end else if (cp_end) begin
				pos_q <= nxt_pos[1:0];
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
			if (!is_pass && cp_end && head.mode == MODE_CAP) begin
				if (sp) begin
					cap_q <= 1'b1;
				end else if (cap_q) begin
					cap_q <= 1'b0;
				end
			end
			// end of string rearms capitalize
			if (grp_done && head.last) begin
				cap_q <= 1'b1;
			end
		end
	end

	// Output register: load on a step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q.out_byte <= ob;
			out_data_q.run_end  <= grp_done;
			out_data_q.out_last <= grp_done && head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hw/rtl/utf8_case_transform_stream_top.sv */
`timescale 1ns / 1ps

// Channel | Handshake          | Payload                       | Beat
// cfg     | cfg_we             | cfg_wdata[1:0] (mode)         | one register write
// in      | in_valid/in_stall  | in_data  {in_byte, in_last}   | one input byte
// out     | out_valid/out_stall| out_data {out_byte, run_end, out_last} | one output byte
//
// Input beats are taken one per cycle while the group queue has room.
// The back emits one output byte per cycle while a group waits and out_stall is low; an input
// byte yields one or more output bytes (usually one; a replaced cut sequence yields up to nine).
// The group queue (QUEUE_DEPTH entries) lets front and back stall independently.
// Reset (arst_n low, asynchronous) clears mode, held count, queue and output valid,
// and arms capitalize; there is no clearing pass.
module utf8_case_transform_stream_top #(
	parameter int QUEUE_DEPTH = ucts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  ucts_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ucts_pkg::out_beat_t out_data
);
	import ucts_pkg::*;

	logic q_full;
	logic q_push;
	grp_t q_push_grp;
	logic q_pop;
	logic q_head_valid;
	grp_t q_head;

	// Accept and classify bytes into groups
	ucts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (q_push),
		.push_grp  (q_push_grp)
	);

	// Buffer groups between the two sides
	ucts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_grp   (q_push_grp),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// Decode, transform and re-encode
	ucts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

/* hw/rtl/ucts_checker.sv */
`timescale 1ns / 1ps

module ucts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [1:0]          cfg_wdata,
	input logic                in_valid,
	input logic                in_stall,
	input ucts_pkg::in_beat_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input ucts_pkg::out_beat_t out_data
);
	import ucts_pkg::*;

	// A stalled output beat stays and holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// The last byte of a string also closes its input byte's run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_last |-> out_data.run_end)
		else $error("out_last without run_end");

	// A reset edge leaves the output and the queue empty
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("beat or stall shown after a reset edge");

	// The queue fills only through an accepted input beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted beat");

endmodule

bind utf8_case_transform_stream_top ucts_checker u_ucts_checker (.*);
